// File: rtl/core/radio_packet_framer_deframer_unit_defines.svh
// Assertion macros for the packet framer/deframer.
// Define NO_ASSERTIONS to compile them out.
`ifndef RADIO_PACKET_FRAMER_DEFRAMER_UNIT_DEFINES_SVH
`define RADIO_PACKET_FRAMER_DEFRAMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define RPFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpfd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpfd: next-cycle check failed");

`else

`define RPFD_ASSERT_NOW(lbl, ante, cons)
`define RPFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/rpfd_pkg.sv
package rpfd_pkg;

  // Sizing
  localparam int MAX_PAYLOAD_DEF = 128;
  localparam int HDR_ENTRIES     = 4;   // group, destination, source, length
  localparam int FRAME_OVERHEAD  = 6;   // header entries plus two CRC bytes

  // Framing bytes and CRC
  localparam logic [7:0]  PREAMBLE  = 8'hAA;
  localparam logic [7:0]  SYNC_WORD = 8'h2D;
  localparam logic [15:0] CRC_SEED  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Operation codes
  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_TX_START = 3'd1;
  localparam logic [2:0] OP_RX_START = 3'd2;
  localparam logic [2:0] OP_FIFO     = 3'd3;
  localparam logic [2:0] OP_READ     = 3'd4;

  // Configuration register indexes
  localparam logic CFG_GROUP = 1'b0;
  localparam logic CFG_NODE  = 1'b1;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] index;
    logic [7:0] data_byte;
    logic [6:0] dest_node;
    logic [7:0] length;
    logic       ack_req;
    logic       ack_reply;
    logic [6:0] ack_from;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       radio_idle;
    logic       rx_done;
    logic       crc_ok;
    logic       addressed;
    logic [6:0] sender_id;
    logic       ack_requested;
    logic       ack_match;
    logic [7:0] rx_length;
    logic [7:0] read_data;
    logic       busy_res;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_TX   = 3'b010,
    MODE_RX   = 3'b100
  } mode_t;

  typedef enum logic [9:0] {
    ST_PRE1  = 10'b00_0000_0001,
    ST_PRE2  = 10'b00_0000_0010,
    ST_PRE3  = 10'b00_0000_0100,
    ST_SYNC  = 10'b00_0000_1000,
    ST_GROUP = 10'b00_0001_0000,
    ST_DATA  = 10'b00_0010_0000,
    ST_CRCL  = 10'b00_0100_0000,
    ST_CRCH  = 10'b00_1000_0000,
    ST_TAIL  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } tx_step_t;

endpackage

// File: rtl/core/rpfd_crc_byte.sv
// Reflected CRC-16 update over one byte, eight shift steps unrolled.
module rpfd_crc_byte (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] result
);
  import rpfd_pkg::*;

  always_comb begin
    result = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      result = result[0] ? ((result >> 1) ^ CRC_POLY) : (result >> 1);
    end
  end

endmodule

// File: rtl/core/radio_packet_framer_deframer_unit.sv
// Packet framer/deframer for a byte-wide radio FIFO. Every transaction on the input
// channel (payload write, start transmit, start receive, FIFO event, buffer read)
// produces exactly one result transaction. The edge that accepts an item launches the
// single, registered read of the packet memory; the item is then processed once the
// result register can take it: the byte CRC runs, the engine state updates and the
// memory is written back. in_stall is high while an item is held, so a new item is
// taken only after the held one is processed. The result register lets the next item
// enter while a result waits; a stalled result holds the processing of the held
// item until out_stall drops. Header bytes (group, destination, source, length) sit
// in registers, the payload in the memory. The memory has no reset and no clearing
// pass: reading a location never written returns whatever it holds.
`include "radio_packet_framer_deframer_unit_defines.svh"
module radio_packet_framer_deframer_unit #(
  parameter int MAX_PAYLOAD = rpfd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpfd_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rpfd_pkg::out_item_t out_item
);
  import rpfd_pkg::*;

  localparam int         STORE_DEPTH = MAX_PAYLOAD + FRAME_OVERHEAD;
  localparam int         AW          = $clog2(STORE_DEPTH);
  localparam logic [8:0] DEPTH_LIM   = 9'(STORE_DEPTH);
  localparam logic [7:0] MAX_LEN     = 8'(MAX_PAYLOAD);
  localparam logic [8:0] HDR_LIM     = 9'(HDR_ENTRIES);
  localparam logic [8:0] LAST_HDR    = 9'(HDR_ENTRIES - 1);
  localparam logic [7:0] END_OFFSET  = 8'(FRAME_OVERHEAD);

  // Configuration
  logic [7:0] network_group;
  logic [6:0] own_node;

  // Engine state
  mode_t      mode, mode_next;
  tx_step_t   tx_step, tx_step_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] fill_count, fill_count_next;
  logic [15:0] running_crc, running_crc_next;

  // Header entries of the packet store
  logic [7:0] hdr_group, hdr_group_next;
  logic [7:0] hdr_dest, hdr_dest_next;
  logic [7:0] hdr_src, hdr_src_next;
  logic [7:0] hdr_len, hdr_len_next;

  // Item stage and read tracking
  logic       stage_valid;
  in_item_t   item;
  logic       in_accept, proceed;
  logic [7:0] rd_addr;
  logic       rd_in_range;
  logic       rd_oob, rd_is_hdr;
  logic [1:0] rd_hdr_sel;
  logic [7:0] hdr_rd, store_rd;

  // Payload memory
  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    mem_rdata;
  logic          wr_req, mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Shared CRC unit
  logic [15:0] crc_c, crc_out;
  logic [7:0]  crc_d;
  out_item_t   res;

  rpfd_crc_byte u_crc (
    .crc    (crc_c),
    .data   (crc_d),
    .result (crc_out)
  );

  assign in_stall  = stage_valid;
  assign in_accept = in_valid && !in_stall;
  assign proceed   = stage_valid && (!out_valid || !out_stall);
  assign mem_we    = proceed && wr_req;

  // Read address: buffer index for a read, current transmit position otherwise
  assign rd_addr     = (in_item.operation == OP_READ) ? in_item.index : byte_position;
  assign rd_in_range = {1'b0, rd_addr} < DEPTH_LIM;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept && rd_in_range) begin
      mem_rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  // Capture the item and where its read byte comes from
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item       <= in_item;
      rd_oob     <= !rd_in_range;
      rd_is_hdr  <= {1'b0, rd_addr} < HDR_LIM;
      rd_hdr_sel <= rd_addr[1:0];
    end
  end

  // Store byte seen by this item
  always_comb begin
    case (rd_hdr_sel)
      2'd0:    hdr_rd = hdr_group;
      2'd1:    hdr_rd = hdr_dest;
      2'd2:    hdr_rd = hdr_src;
      default: hdr_rd = hdr_len;
    endcase
    if (rd_oob) begin
      store_rd = 8'h00;
    end else if (rd_is_hdr) begin
      store_rd = hdr_rd;
    end else begin
      store_rd = mem_rdata;
    end
  end

  // CRC operand selection
  always_comb begin
    crc_c = running_crc;
    crc_d = store_rd;
    unique case (item.operation) inside
      OP_TX_START, OP_RX_START: begin
        crc_c = CRC_SEED;
        crc_d = network_group;
      end
      OP_FIFO: begin
        crc_d = (mode == MODE_RX) ? item.data_byte : store_rd;
      end
      default: ;
    endcase
  end

  // Item processing: next state, memory write-back and result
  always_comb begin
    logic [7:0] len_sat;
    logic [7:0] fc;
    logic [7:0] fc_inc;
    logic [7:0] rx_end;
    logic       ok;
    logic [6:0] d;
    logic [6:0] s;

    mode_next          = mode;
    tx_step_next       = tx_step;
    byte_position_next = byte_position;
    fill_count_next    = fill_count;
    running_crc_next   = running_crc;
    hdr_group_next     = hdr_group;
    hdr_dest_next      = hdr_dest;
    hdr_src_next       = hdr_src;
    hdr_len_next       = hdr_len;
    wr_req             = 1'b0;
    mem_waddr          = '0;
    mem_wdata          = item.data_byte;
    res                = '0;
    len_sat            = (item.length > MAX_LEN) ? MAX_LEN : item.length;
    fc                 = fill_count;
    fc_inc             = fill_count;
    rx_end             = 8'h00;
    ok                 = 1'b0;
    d                  = 7'h00;
    s                  = 7'h00;

    unique case (item.operation) inside
      OP_WRITE: begin
        if (mode == MODE_IDLE && item.index < MAX_LEN) begin
          wr_req    = 1'b1;
          mem_waddr = AW'({1'b0, item.index} + HDR_LIM);
        end
      end

      OP_TX_START: begin
        if (mode == MODE_IDLE || (mode == MODE_RX && fill_count == 8'h00)) begin
          hdr_dest_next      = {item.ack_reply, item.dest_node};
          hdr_src_next       = {item.ack_req, own_node};
          hdr_len_next       = len_sat;
          running_crc_next   = crc_out;
          mode_next          = MODE_TX;
          tx_step_next       = ST_PRE1;
          byte_position_next = 8'h00;
        end
      end

      OP_RX_START: begin
        if (mode == MODE_IDLE) begin
          fill_count_next  = 8'h00;
          hdr_len_next     = 8'h00;
          running_crc_next = (network_group != 8'h00) ? crc_out : CRC_SEED;
          mode_next        = MODE_RX;
        end
      end

      OP_FIFO: begin
        if (mode == MODE_TX) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = PREAMBLE;
          unique case (tx_step)
            ST_PRE1: tx_step_next = ST_PRE2;
            ST_PRE2: tx_step_next = ST_PRE3;
            ST_PRE3: tx_step_next = ST_SYNC;
            ST_SYNC: begin
              res.tx_byte  = SYNC_WORD;
              tx_step_next = ST_GROUP;
            end
            ST_GROUP: begin
              res.tx_byte        = network_group;
              tx_step_next       = ST_DATA;
              byte_position_next = 8'h01;
            end
            ST_DATA: begin
              res.tx_byte      = store_rd;
              running_crc_next = crc_out;
              if ({1'b0, byte_position} >= LAST_HDR + {1'b0, hdr_len}) begin
                tx_step_next = ST_CRCL;
              end else begin
                byte_position_next = byte_position + 8'h01;
              end
            end
            ST_CRCL: begin
              res.tx_byte  = running_crc[7:0];
              tx_step_next = ST_CRCH;
            end
            ST_CRCH: begin
              res.tx_byte  = running_crc[15:8];
              tx_step_next = ST_TAIL;
            end
            ST_TAIL: tx_step_next = ST_DONE;
            ST_DONE: begin
              res.radio_idle = 1'b1;
              mode_next      = MODE_IDLE;
              tx_step_next   = ST_PRE1;
            end
            default: tx_step_next = ST_DONE;
          endcase
        end else if (mode == MODE_RX) begin
          // group byte is implied when a group is set
          if (fill_count == 8'h00 && network_group != 8'h00) begin
            hdr_group_next = network_group;
            fc             = 8'h01;
          end
          if ({1'b0, fc} < HDR_LIM) begin
            case (fc[1:0])
              2'd0:    hdr_group_next = item.data_byte;
              2'd1:    hdr_dest_next  = item.data_byte;
              2'd2:    hdr_src_next   = item.data_byte;
              default: hdr_len_next   = item.data_byte;
            endcase
          end else if ({1'b0, fc} < DEPTH_LIM) begin
            wr_req    = 1'b1;
            mem_waddr = fc[AW-1:0];
          end
          fc_inc           = (fc != 8'hFF) ? fc + 8'h01 : fc;
          fill_count_next  = fc_inc;
          running_crc_next = crc_out;
          rx_end           = hdr_len_next + END_OFFSET;
          if (fc_inc >= rx_end || {1'b0, fc_inc} >= DEPTH_LIM) begin
            d                 = hdr_dest_next[6:0];
            s                 = hdr_src_next[6:0];
            ok                = (crc_out == 16'h0000) && (hdr_len_next <= MAX_LEN);
            mode_next         = MODE_IDLE;
            res.radio_idle    = 1'b1;
            res.rx_done       = 1'b1;
            res.crc_ok        = ok;
            res.addressed     = (d == 7'h00) || (d == own_node);
            res.sender_id     = s;
            res.ack_requested = hdr_src_next[7] && !hdr_dest_next[7];
            res.ack_match     = ok && (d == own_node) &&
                                ((s == item.ack_from) || (item.ack_from == 7'h00)) &&
                                hdr_dest_next[7] && !hdr_src_next[7];
            res.rx_length     = hdr_len_next;
          end
        end
      end

      OP_READ: res.read_data = store_rd;

      default: ;
    endcase

    res.busy_res = (mode_next != MODE_IDLE);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      network_group <= 8'h00;
      own_node      <= 7'h00;
      stage_valid   <= 1'b0;
      out_valid     <= 1'b0;
      mode          <= MODE_IDLE;
      tx_step       <= ST_PRE1;
      byte_position <= 8'h00;
      fill_count    <= 8'h00;
      running_crc   <= CRC_SEED;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_GROUP) begin
          network_group <= cfg_data;
        end else if (cfg_index == CFG_NODE) begin
          own_node <= cfg_data[6:0];
        end
      end

      if (in_accept) begin
        stage_valid <= 1'b1;
      end else if (proceed) begin
        stage_valid <= 1'b0;
      end

      if (proceed) begin
        out_valid     <= 1'b1;
        mode          <= mode_next;
        tx_step       <= tx_step_next;
        byte_position <= byte_position_next;
        fill_count    <= fill_count_next;
        running_crc   <= running_crc_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Header entries and result payload
  always_ff @(posedge clk) begin
    if (proceed) begin
      hdr_group <= hdr_group_next;
      hdr_dest  <= hdr_dest_next;
      hdr_src   <= hdr_src_next;
      hdr_len   <= hdr_len_next;
      out_item  <= res;
    end
  end

  // Checks
  `RPFD_ASSERT_NEXT(a_result_follows, proceed, out_valid)
  `RPFD_ASSERT_NOW(a_no_read_on_write, mem_we, !in_accept)
  `RPFD_ASSERT_NOW(a_step_parked, mode != MODE_TX, tx_step == ST_PRE1)
  `RPFD_ASSERT_NOW(a_fill_bounded, mode == MODE_RX, 9'(fill_count) < DEPTH_LIM)

endmodule
